// ===== rtl/core/bnlf_pkg.sv =====
// Shared types and constants for the binary neighbourhood lookup filter.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none

package bnlf_pkg;

    // Fixed field widths
    localparam int WidthBits    = 6;
    localparam int CountBits    = 7;
    localparam int TotalBits    = 16;
    localparam int GroupBits    = 4;
    localparam int GroupLanes   = 8;

    // Lookup table geometry
    localparam int TableEntries = 512;
    localparam int IndexBits    = 9;
    localparam int TableWords   = 8;
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = 64;

    localparam logic [TotalBits-1:0] TotalMax = {TotalBits{1'b1}};

    // Control that travels with a window into the lane array
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [WidthBits-1:0] width;
    } win_ctrl_t;

    // Control that travels with a finished pixel row into the merge stage
    typedef struct packed {
        logic valid;
        logic last;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bnlf_if.sv =====
// Valid/ready channel interfaces for input rows and output rows.
// Depends on bnlf_pkg for the fixed field widths.
`default_nettype none

interface bnlf_in_if
    import bnlf_pkg::*;
#(
    parameter int MAX_WIDTH = 62
) ();
    logic                 valid;
    logic                 ready;
    logic [MAX_WIDTH-1:0] pixel_row;
    logic [WidthBits-1:0] row_width;
    logic                 border_value;
    logic                 last_row;

    modport source (
        output valid, pixel_row, row_width, border_value, last_row,
        input  ready
    );
    modport sink (
        input  valid, pixel_row, row_width, border_value, last_row,
        output ready
    );
endinterface

interface bnlf_out_if
    import bnlf_pkg::*;
#(
    parameter int MAX_WIDTH = 62
) ();
    logic                 valid;
    logic                 ready;
    logic [MAX_WIDTH+1:0] out_row;
    logic [CountBits-1:0] row_lit_count;
    logic [TotalBits-1:0] frame_lit_total;
    logic                 last_out;

    modport source (
        output valid, out_row, row_lit_count, frame_lit_total, last_out,
        input  ready
    );
    modport sink (
        input  valid, out_row, row_lit_count, frame_lit_total, last_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/binary_neighbourhood_lut_filter_top.sv =====
// Binary 3x3 neighbourhood lookup filter, one pass, one image row per request.
//
// Channels: pix_in carries a row (pixel_row, row_width, border_value,
// last_row); row_out carries output rows MAX_WIDTH+2 bits wide with the row
// and running frame lit counts. Both use valid/ready; a request moves when
// valid and ready are high at a rising clock edge. The 512-entry table is
// written through cfg_write/cfg_index/cfg_data, 64 entries per register.
//
// A row's first result passes through the issue, window, lane and output
// registers in that order after its request is accepted.
// Throughput: one row per cycle while row_out does not stall; a row marked
// last_row gives three results and holds the input while the issue register
// steps through its three windows.
//
// Reset clears the table, the row history and the frame total. When row_out
// stalls, the stall backs up through the pipeline registers and pix_in.ready
// drops once they are full; no result is lost or repeated.
// Depends on bnlf_pkg, bnlf_if, bnlf_window, bnlf_lane_array, bnlf_merge.
`default_nettype none

module binary_neighbourhood_lut_filter_top
    import bnlf_pkg::*;
#(
    parameter int MAX_WIDTH = 62
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    bnlf_in_if.sink                      pix_in,
    bnlf_out_if.source                   row_out,
    input  wire logic                    cfg_write,
    input  wire logic [CfgIndexBits-1:0] cfg_index,
    input  wire logic [CfgDataBits-1:0]  cfg_data
);

    localparam int NumGroups = (MAX_WIDTH + 9) / 8;

    logic [CfgDataBits-1:0]  table_word_reg [TableWords];
    logic [TableEntries-1:0] table_bits;

    win_ctrl_t               win_ctrl;
    logic [MAX_WIDTH+3:0]    win_top, win_mid, win_bot;
    logic                    lane_ready;
    lane_ctrl_t              px_ctrl;
    logic [MAX_WIDTH+1:0]    px_row;
    logic [NumGroups-1:0][GroupBits-1:0] grp_count;
    logic                    merge_ready;

    // Table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TableWords; k++)
            begin
                table_word_reg[k] <= '0;
            end
        end
        else if (cfg_write)
        begin
            table_word_reg[cfg_index] <= cfg_data;
        end
    end

    // Flatten the table: entry 64*k+i is bit i of register k
    always_comb
    begin
        for (int k = 0; k < TableWords; k++)
        begin
            table_bits[k*CfgDataBits +: CfgDataBits] = table_word_reg[k];
        end
    end

    bnlf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .lane_ready (lane_ready),
        .win_ctrl   (win_ctrl),
        .win_top    (win_top),
        .win_mid    (win_mid),
        .win_bot    (win_bot)
    );

    bnlf_lane_array #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lanes (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_bits  (table_bits),
        .win_ctrl    (win_ctrl),
        .win_top     (win_top),
        .win_mid     (win_mid),
        .win_bot     (win_bot),
        .merge_ready (merge_ready),
        .lane_ready  (lane_ready),
        .px_ctrl     (px_ctrl),
        .px_row      (px_row),
        .grp_count   (grp_count)
    );

    bnlf_merge #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .px_ctrl     (px_ctrl),
        .px_row      (px_row),
        .grp_count   (grp_count),
        .merge_ready (merge_ready),
        .row_out     (row_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bnlf_window.sv =====
// Row history, request issue and padded 3x3 window rows for the lane array.
// Depends on bnlf_pkg and bnlf_in_if.
`default_nettype none

module bnlf_window
    import bnlf_pkg::*;
#(
    parameter int MAX_WIDTH = 62
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    bnlf_in_if.sink               pix_in,
    input  wire logic             lane_ready,
    output win_ctrl_t             win_ctrl,
    output logic [MAX_WIDTH+3:0]  win_top,
    output logic [MAX_WIDTH+3:0]  win_mid,
    output logic [MAX_WIDTH+3:0]  win_bot
);

    localparam int PadBits = MAX_WIDTH + 4;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } phase_t;

    // Frame history
    logic [MAX_WIDTH-1:0] hist_upper_reg, hist_upper_next;
    logic [MAX_WIDTH-1:0] hist_middle_reg, hist_middle_next;
    logic [1:0]           rows_seen_reg, rows_seen_next;

    // Issue register: one accepted request, emitted as one or three windows
    logic                 iss_v_reg;
    phase_t               phase_reg, phase_next;
    logic [MAX_WIDTH-1:0] iss_upper_reg, iss_middle_reg, iss_cur_reg;
    logic                 iss_up_b_reg, iss_mid_b_reg;
    logic [WidthBits-1:0] iss_w_reg;
    logic                 iss_b_reg;
    logic                 iss_last_reg;

    // Window register
    logic                 win_v_reg;
    logic                 win_last_reg;
    logic [WidthBits-1:0] win_w_reg;
    logic [PadBits-1:0]   win_top_reg, win_mid_reg, win_bot_reg;

    logic [WidthBits-1:0] w_sat;
    logic [MAX_WIDTH-1:0] cur_masked;
    logic                 accept;
    logic                 win_ready;
    logic                 emit;
    logic                 final_phase;
    logic                 issue_done;

    logic [MAX_WIDTH-1:0] sel_top, sel_mid, sel_bot;
    logic                 sel_top_b, sel_mid_b, sel_bot_b;
    logic [PadBits-1:0]   pad_top, pad_mid, pad_bot;

    // Width saturation and stray-bit masking of the incoming row
    always_comb
    begin
        w_sat = (pix_in.row_width > WidthBits'(MAX_WIDTH)) ? WidthBits'(MAX_WIDTH)
                                                           : pix_in.row_width;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            cur_masked[c] = pix_in.pixel_row[c] & (WidthBits'(c) < w_sat);
        end
    end

    // Handshake: take a new request once the current one issues its final window
    assign win_ready   = !win_v_reg || lane_ready;
    assign emit        = iss_v_reg && win_ready;
    assign final_phase = !iss_last_reg || (phase_reg == PH_THIRD);
    assign issue_done  = emit && final_phase;
    assign pix_in.ready = !iss_v_reg || issue_done;
    assign accept      = pix_in.valid && pix_in.ready;

    // History update at acceptance
    always_comb
    begin
        hist_upper_next  = hist_upper_reg;
        hist_middle_next = hist_middle_reg;
        rows_seen_next   = rows_seen_reg;
        if (accept)
        begin
            if (pix_in.last_row)
            begin
                hist_upper_next  = '0;
                hist_middle_next = '0;
                rows_seen_next   = '0;
            end
            else
            begin
                hist_upper_next  = hist_middle_reg;
                hist_middle_next = cur_masked;
                rows_seen_next   = (rows_seen_reg == 2'd2) ? 2'd2 : rows_seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_upper_reg  <= '0;
            hist_middle_reg <= '0;
            rows_seen_reg   <= '0;
        end
        else
        begin
            hist_upper_reg  <= hist_upper_next;
            hist_middle_reg <= hist_middle_next;
            rows_seen_reg   <= rows_seen_next;
        end
    end

    // Phase sequencing
    always_comb
    begin
        unique case (phase_reg)
            PH_FIRST:  phase_next = PH_SECOND;
            PH_SECOND: phase_next = PH_THIRD;
            PH_THIRD:  phase_next = PH_THIRD;
            default:   phase_next = PH_FIRST;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_v_reg <= 1'b0;
            phase_reg <= PH_FIRST;
        end
        else if (accept)
        begin
            iss_v_reg <= 1'b1;
            phase_reg <= PH_FIRST;
        end
        else if (issue_done)
        begin
            iss_v_reg <= 1'b0;
        end
        else if (emit)
        begin
            phase_reg <= phase_next;
        end
    end

    // Issue payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            iss_upper_reg  <= hist_upper_reg;
            iss_middle_reg <= hist_middle_reg;
            iss_cur_reg    <= cur_masked;
            iss_up_b_reg   <= (rows_seen_reg < 2'd2);
            iss_mid_b_reg  <= (rows_seen_reg == 2'd0);
            iss_w_reg      <= w_sat;
            iss_b_reg      <= pix_in.border_value;
            iss_last_reg   <= pix_in.last_row;
        end
    end

    // Row selection per phase: top output row, then the two closing rows
    always_comb
    begin
        unique case (phase_reg)
            PH_SECOND:
            begin
                sel_top = iss_middle_reg; sel_top_b = iss_mid_b_reg;
                sel_mid = iss_cur_reg;    sel_mid_b = 1'b0;
                sel_bot = '0;             sel_bot_b = 1'b1;
            end
            PH_THIRD:
            begin
                sel_top = iss_cur_reg;    sel_top_b = 1'b0;
                sel_mid = '0;             sel_mid_b = 1'b1;
                sel_bot = '0;             sel_bot_b = 1'b1;
            end
            default:
            begin
                sel_top = iss_upper_reg;  sel_top_b = iss_up_b_reg;
                sel_mid = iss_middle_reg; sel_mid_b = iss_mid_b_reg;
                sel_bot = iss_cur_reg;    sel_bot_b = 1'b0;
            end
        endcase
    end

    // Padding: pad bit k holds column k-2, border outside the image
    always_comb
    begin
        for (int k = 0; k < PadBits; k++)
        begin
            if (k < 2 || k >= MAX_WIDTH + 2)
            begin
                pad_top[k] = iss_b_reg;
                pad_mid[k] = iss_b_reg;
                pad_bot[k] = iss_b_reg;
            end
            else
            begin
                pad_top[k] = (sel_top_b || !(WidthBits'(k - 2) < iss_w_reg)) ? iss_b_reg
                                                                          : sel_top[k-2];
                pad_mid[k] = (sel_mid_b || !(WidthBits'(k - 2) < iss_w_reg)) ? iss_b_reg
                                                                          : sel_mid[k-2];
                pad_bot[k] = (sel_bot_b || !(WidthBits'(k - 2) < iss_w_reg)) ? iss_b_reg
                                                                          : sel_bot[k-2];
            end
        end
    end

    // Window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_v_reg <= 1'b0;
        end
        else if (win_ready)
        begin
            win_v_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            win_last_reg <= iss_last_reg && (phase_reg == PH_THIRD);
            win_w_reg    <= iss_w_reg;
            win_top_reg  <= pad_top;
            win_mid_reg  <= pad_mid;
            win_bot_reg  <= pad_bot;
        end
    end

    assign win_ctrl.valid = win_v_reg;
    assign win_ctrl.last  = win_last_reg;
    assign win_ctrl.width = win_w_reg;
    assign win_top        = win_top_reg;
    assign win_mid        = win_mid_reg;
    assign win_bot        = win_bot_reg;

    // Checks
    a_phase_last: assert property (@(posedge clk) disable iff (!rst_n)
        iss_v_reg && (phase_reg != PH_FIRST) |-> iss_last_reg)
        else $error("closing phase on a request that is not the last row");

    a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rows_seen_reg != 2'd3)
        else $error("rows_seen passed its saturation point");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pix_in.last_row |=> (rows_seen_reg == 2'd0))
        else $error("history not cleared after the last row");

    a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
        win_v_reg && !lane_ready |=> win_v_reg && $stable(win_top_reg)
                                     && $stable(win_last_reg))
        else $error("window changed while the lane array stalled");

endmodule

`default_nettype wire

// ===== rtl/core/bnlf_lane.sv =====
// One lane: table lookup for one output pixel from its 9-bit window index.
// Depends on bnlf_pkg for the table geometry.
`default_nettype none

module bnlf_lane
    import bnlf_pkg::*;
(
    input  wire logic [TableEntries-1:0] table_bits,
    input  wire logic [IndexBits-1:0]    idx,
    input  wire logic                    en,
    output logic                         px
);

    // Lanes beyond the output width, the row width plus two, give zero
    assign px = en & table_bits[idx];

endmodule

`default_nettype wire

// ===== rtl/core/bnlf_lane_array.sv =====
// Lane array: one lookup lane per output column, pixel row register and
// per-group lit counts. Depends on bnlf_pkg and bnlf_lane.
`default_nettype none

module bnlf_lane_array
    import bnlf_pkg::*;
#(
    parameter int MAX_WIDTH = 62
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [TableEntries-1:0] table_bits,
    input  wire win_ctrl_t               win_ctrl,
    input  wire logic [MAX_WIDTH+3:0]    win_top,
    input  wire logic [MAX_WIDTH+3:0]    win_mid,
    input  wire logic [MAX_WIDTH+3:0]    win_bot,
    input  wire logic                    merge_ready,
    output logic                         lane_ready,
    output lane_ctrl_t                   px_ctrl,
    output logic [MAX_WIDTH+1:0]         px_row,
    output logic [(MAX_WIDTH+9)/8-1:0][GroupBits-1:0] grp_count
);

    localparam int OutBits   = MAX_WIDTH + 2;
    localparam int NumGroups = (OutBits + GroupLanes - 1) / GroupLanes;

    logic [OutBits-1:0]   px_next;
    logic [CountBits-1:0] lane_lim;
    logic [NumGroups-1:0][GroupBits-1:0] grp_next;

    logic                 px_v_reg;
    logic                 px_last_reg;
    logic [OutBits-1:0]   px_row_reg;
    logic [NumGroups-1:0][GroupBits-1:0] grp_count_reg;

    assign lane_ready = !px_v_reg || merge_ready;
    assign lane_lim   = {1'b0, win_ctrl.width} + CountBits'(2);

    // Lanes: output column j sees padded columns j..j+2, top-left as MSB
    for (genvar j = 0; j < OutBits; j++)
    begin : g_lane
        bnlf_lane u_lane (
            .table_bits (table_bits),
            .idx        ({win_top[j], win_top[j+1], win_top[j+2],
                          win_mid[j], win_mid[j+1], win_mid[j+2],
                          win_bot[j], win_bot[j+1], win_bot[j+2]}),
            .en         (CountBits'(j) < lane_lim),
            .px         (px_next[j])
        );
    end

    // First level of the lit count tree: eight lanes per group
    always_comb
    begin
        for (int g = 0; g < NumGroups; g++)
        begin
            grp_next[g] = '0;
            for (int i = 0; i < GroupLanes; i++)
            begin
                if (g * GroupLanes + i < OutBits)
                begin
                    grp_next[g] = grp_next[g] + GroupBits'(px_next[g * GroupLanes + i]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_v_reg <= 1'b0;
        end
        else if (lane_ready)
        begin
            px_v_reg <= win_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_ready)
        begin
            px_last_reg   <= win_ctrl.last;
            px_row_reg    <= px_next;
            grp_count_reg <= grp_next;
        end
    end

    assign px_ctrl.valid = px_v_reg;
    assign px_ctrl.last  = px_last_reg;
    assign px_row        = px_row_reg;
    assign grp_count     = grp_count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bnlf_merge.sv =====
// Merge stage: sums the lane group counts, keeps the saturating frame total
// and holds the output register. Depends on bnlf_pkg and bnlf_out_if.
`default_nettype none

module bnlf_merge
    import bnlf_pkg::*;
#(
    parameter int MAX_WIDTH = 62
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lane_ctrl_t            px_ctrl,
    input  wire logic [MAX_WIDTH+1:0]  px_row,
    input  wire logic [(MAX_WIDTH+9)/8-1:0][GroupBits-1:0] grp_count,
    output logic                       merge_ready,
    bnlf_out_if.source                 row_out
);

    localparam int NumGroups = (MAX_WIDTH + 9) / 8;

    logic [CountBits-1:0] row_cnt;
    logic [TotalBits:0]   sum_wide;
    logic [TotalBits-1:0] total_new;

    logic [TotalBits-1:0] total_reg;
    logic                 out_v_reg;
    logic [MAX_WIDTH+1:0] out_row_reg;
    logic [CountBits-1:0] out_cnt_reg;
    logic [TotalBits-1:0] out_total_reg;
    logic                 out_last_reg;

    assign merge_ready = !out_v_reg || row_out.ready;

    // Row count and saturating frame total
    always_comb
    begin
        row_cnt = '0;
        for (int g = 0; g < NumGroups; g++)
        begin
            row_cnt = row_cnt + CountBits'(grp_count[g]);
        end
        sum_wide  = {1'b0, total_reg} + (TotalBits+1)'(row_cnt);
        total_new = sum_wide[TotalBits] ? TotalMax : sum_wide[TotalBits-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            total_reg <= '0;
        end
        else if (merge_ready)
        begin
            out_v_reg <= px_ctrl.valid;
            if (px_ctrl.valid)
            begin
                total_reg <= px_ctrl.last ? '0 : total_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge_ready)
        begin
            out_row_reg   <= px_row;
            out_cnt_reg   <= row_cnt;
            out_total_reg <= total_new;
            out_last_reg  <= px_ctrl.last;
        end
    end

    assign row_out.valid           = out_v_reg;
    assign row_out.out_row         = out_row_reg;
    assign row_out.row_lit_count   = out_cnt_reg;
    assign row_out.frame_lit_total = out_total_reg;
    assign row_out.last_out        = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/tb_binary_neighbourhood_lut_filter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the binary 3x3 lookup-table filter top level.
// Depends on bnlf_pkg, bnlf_if and binary_neighbourhood_lut_filter_top; a
// scoreboard class predicts each output row and checks it on arrival.

module tb_binary_neighbourhood_lut_filter_top;
    import bnlf_pkg::*;

    localparam int MaxWidth      = 62;
    localparam int OutBits       = MaxWidth + 2;
    localparam int RandomRows    = 410;
    localparam int RowsPerTable  = 70;
    localparam int SettleCycles  = 5;
    localparam int WatchdogLimit = 2000;
    localparam int MaxPrinted    = 40;

    typedef logic [MaxWidth-1:0] pixels_t;
    typedef logic [TableWords-1:0][CfgDataBits-1:0] lut_image_t;

    // Register map of the configuration port
    typedef enum logic [CfgIndexBits-1:0] {
        TABLE_WORD_0, TABLE_WORD_1, TABLE_WORD_2, TABLE_WORD_3,
        TABLE_WORD_4, TABLE_WORD_5, TABLE_WORD_6, TABLE_WORD_7
    } table_reg_t;

    // Table contents used across the run
    typedef enum int {
        LUT_ZERO, LUT_ONES, LUT_RANDOM, LUT_SPARSE, LUT_DENSE, LUT_PASS, LUT_LIFE
    } lut_kind_t;

    // Receiver back-pressure styles
    typedef enum int { RX_FREE, RX_COIN, RX_SPARSE, RX_LONG } rx_mode_t;

    typedef struct packed {
        logic [OutBits-1:0]   out_row;
        logic [CountBits-1:0] lit_count;
        logic [TotalBits-1:0] lit_total;
        logic                 last;
    } row_result_t;

    // Scoreboard: mirrors the filter state and holds the rows still to come
    class lut_filter_scoreboard;
        lut_image_t  lut;
        pixels_t     upper_row;
        pixels_t     middle_row;
        int          rows_seen;
        int          lit_total;
        int          errors;
        row_result_t expected_rows[$];

        function new();
            lut        = '0;
            upper_row  = '0;
            middle_row = '0;
            rows_seen  = 0;
            lit_total  = 0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        task report(string msg);
            errors++;
            // keep the log short when the block is badly broken
            if (errors <= MaxPrinted)
                $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        // Outside the image, or in a row not yet seen, a pixel is the border
        function bit window_px(pixels_t bits, bit is_border, int col, int w, bit border);
            if (is_border || col < 0 || col >= w)
                return border;
            return bits[col];
        endfunction

        // One output row from three window rows; rows[0] is the top row
        function row_result_t filtered_row(logic [2:0][MaxWidth-1:0] rows, bit [2:0] brd,
                                           int w, bit border, bit last);
            row_result_t res;
            logic [IndexBits-1:0] idx;
            int cnt;
            res = '0;
            cnt = 0;
            for (int j = 0; j < w + 2; j++)
            begin
                idx = '0;
                for (int r = 0; r < 3; r++)
                    for (int dx = -1; dx <= 1; dx++)
                        idx = {idx[IndexBits-2:0], window_px(rows[r], brd[r], j - 1 + dx, w,
                                                             border)};
                if (lut[idx[8:6]][idx[5:0]])
                begin
                    res.out_row[j] = 1'b1;
                    cnt++;
                end
            end
            lit_total = (lit_total + cnt > int'(TotalMax)) ? int'(TotalMax) : lit_total + cnt;
            res.lit_count = CountBits'(cnt);
            res.lit_total = TotalBits'(lit_total);
            res.last      = last;
            return res;
        endfunction

        // Accepted request: predict the one or three rows it gives
        function void note_request(pixels_t pixel_row, logic [WidthBits-1:0] row_width,
                                   bit border, bit last);
            int w;
            pixels_t cur;
            bit up_b;
            bit mid_b;
            w     = (row_width > MaxWidth) ? MaxWidth : int'(row_width);
            cur   = pixel_row & MaxWidth'((64'd1 << w) - 64'd1);
            up_b  = rows_seen < 2;
            mid_b = rows_seen < 1;
            expected_rows.push_back(filtered_row({cur, middle_row, upper_row},
                                                 {1'b0, mid_b, up_b}, w, border, 1'b0));
            if (!last)
            begin
                upper_row  = middle_row;
                middle_row = cur;
                if (rows_seen < 2)
                    rows_seen++;
            end
            else
            begin
                // bottom edge: two more rows with border below the image
                expected_rows.push_back(filtered_row({pixels_t'(0), cur, middle_row},
                                                     {1'b1, 1'b0, mid_b}, w, border, 1'b0));
                expected_rows.push_back(filtered_row({pixels_t'(0), pixels_t'(0), cur},
                                                     {1'b1, 1'b1, 1'b0}, w, border, 1'b1));
                upper_row  = '0;
                middle_row = '0;
                rows_seen  = 0;
                lit_total  = 0;
            end
        endfunction

        task check_result(logic [OutBits-1:0] out_row, logic [CountBits-1:0] lit_count,
                          logic [TotalBits-1:0] lit_total_in, logic last);
            row_result_t exp_row;
            if (expected_rows.size() == 0)
            begin
                report($sformatf("output row %h with no request pending", out_row));
                return;
            end
            exp_row = expected_rows.pop_front();
            if (out_row !== exp_row.out_row)
                report($sformatf("out_row got %h expected %h", out_row, exp_row.out_row));
            if (lit_count !== exp_row.lit_count)
                report($sformatf("row_lit_count got %0d expected %0d",
                                 lit_count, exp_row.lit_count));
            if (lit_total_in !== exp_row.lit_total)
                report($sformatf("frame_lit_total got %0d expected %0d",
                                 lit_total_in, exp_row.lit_total));
            if (last !== exp_row.last)
                report($sformatf("last_out got %b expected %b", last, exp_row.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                    cfg_write;
    logic [CfgIndexBits-1:0] cfg_index;
    logic [CfgDataBits-1:0]  cfg_data;

    bnlf_in_if  #(.MAX_WIDTH(MaxWidth)) pix_in_if ();
    bnlf_out_if #(.MAX_WIDTH(MaxWidth)) row_out_if ();

    lut_filter_scoreboard sb;
    int burst_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    rx_mode_t rx_mode = RX_FREE;

    binary_neighbourhood_lut_filter_top #(.MAX_WIDTH(MaxWidth)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in_if),
        .row_out   (row_out_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic pixels_t rand_pixels();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[MaxWidth-1:0];
    endfunction

    // Table images; the pass pattern copies the center pixel through
    function automatic lut_image_t build_table(lut_kind_t kind);
        lut_image_t img;
        logic [IndexBits-1:0] idx;
        int n;
        img = '0;
        for (int k = 0; k < TableWords; k++)
        begin
            case (kind)
                LUT_ONES:   img[k] = '1;
                LUT_RANDOM: img[k] = {$urandom, $urandom};
                LUT_SPARSE: img[k] = {$urandom, $urandom} & {$urandom, $urandom};
                LUT_DENSE:  img[k] = {$urandom, $urandom} | {$urandom, $urandom};
                LUT_PASS:   img[k] = 64'hFFFF_0000_FFFF_0000;
                default:    img[k] = '0;
            endcase
        end
        if (kind == LUT_LIFE)
        begin
            for (int i = 0; i < TableEntries; i++)
            begin
                idx = IndexBits'(i);
                n = $countones(idx) - int'(idx[4]);
                img[idx[8:6]][idx[5:0]] = (n == 3) || (idx[4] && n == 2);
            end
        end
        return img;
    endfunction

    // Send one request, with a random gap at the start of each burst
    task automatic send_row(pixels_t pixel_row, logic [WidthBits-1:0] row_width,
                            bit border, bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                pix_in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_in_if.valid        <= 1'b1;
        pix_in_if.pixel_row    <= pixel_row;
        pix_in_if.row_width    <= row_width;
        pix_in_if.border_value <= border;
        pix_in_if.last_row     <= last;
        do
            @(posedge clk);
        while (!pix_in_if.ready);
        sb.note_request(pixel_row, row_width, border, last);
    endtask

    // Hold the input until every predicted row has come out
    task automatic drain_rows();
        pix_in_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Write all eight table words while the block is idle
    task automatic load_table(lut_image_t img);
        drain_rows();
        repeat (SettleCycles) @(posedge clk);
        for (int k = 0; k < TableWords; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= table_reg_t'(k);
            cfg_data  <= img[k];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        sb.lut = img;
    endtask

    // Receiver stalls, switching to a randomly chosen style when stall_left runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            rx_mode    = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (rx_mode)
            RX_FREE:   row_out_if.ready <= 1'b1;
            RX_COIN:   row_out_if.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: row_out_if.ready <= ($urandom_range(0, 3) == 0);
            default:   row_out_if.ready <= (stall_left % 16) >= 12;
        endcase
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && row_out_if.valid && row_out_if.ready)
            sb.check_result(row_out_if.out_row, row_out_if.row_lit_count,
                            row_out_if.frame_lit_total, row_out_if.last_out);
    end

    // Watchdog on cycles with no request moving on either channel
    always @(posedge clk)
    begin
        if ((pix_in_if.valid && pix_in_if.ready) || (row_out_if.valid && row_out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("tb_binary_neighbourhood_lut_filter_top: FAIL");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int height;
        int width;
        int next_table_at;
        int random_rows;
        bit mixed_width;
        bit mixed_border;
        bit border;
        pixels_t pix;

        sb = new();
        rst_n                  = 1'b0;
        cfg_write              = 1'b0;
        cfg_index              = TABLE_WORD_0;
        cfg_data               = '0;
        pix_in_if.valid        = 1'b0;
        pix_in_if.pixel_row    = '0;
        pix_in_if.row_width    = '0;
        pix_in_if.border_value = 1'b0;
        pix_in_if.last_row     = 1'b0;
        row_out_if.ready       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table is still all zero after reset
        send_row('1, WidthBits'(MaxWidth), 1'b1, 1'b1);

        // no columns, then a width above the maximum
        load_table(build_table(LUT_ONES));
        send_row(rand_pixels(), 0, 1'b0, 1'b1);
        send_row(rand_pixels(), 63, 1'b1, 1'b1);

        // one-column and full-width frames, stray bits above the width
        load_table(build_table(LUT_LIFE));
        send_row(rand_pixels(), 1, 1'b0, 1'b0);
        send_row('1, 1, 1'b0, 1'b1);
        send_row(62'h2AAA_AAAA_AAAA_AAAA, WidthBits'(MaxWidth), 1'b1, 1'b0);
        send_row(rand_pixels(), WidthBits'(MaxWidth), 1'b1, 1'b0);
        send_row(62'h1555_5555_5555_5555, WidthBits'(MaxWidth), 1'b1, 1'b1);
        send_row('1, 10, 1'b0, 1'b0);
        send_row('1, 10, 1'b0, 1'b1);

        // width changing and border changing inside a frame
        load_table(build_table(LUT_PASS));
        send_row(rand_pixels(), 20, 1'b0, 1'b0);
        send_row(rand_pixels(), 5, 1'b0, 1'b0);
        send_row(rand_pixels(), 40, 1'b0, 1'b1);
        send_row(rand_pixels(), 30, 1'b0, 1'b0);
        send_row(rand_pixels(), 30, 1'b1, 1'b0);
        send_row(rand_pixels(), 30, 1'b0, 1'b0);
        send_row(rand_pixels(), 30, 1'b1, 1'b1);

        load_table(build_table(LUT_RANDOM));
        for (int r = 0; r < 4; r++)
            send_row(rand_pixels(), WidthBits'(MaxWidth), 1'(r), r == 3);

        // random frames, with a new table every few dozen rows
        random_rows   = 0;
        next_table_at = 0;
        while (random_rows < RandomRows)
        begin
            if (random_rows >= next_table_at)
            begin
                load_table(build_table(lut_kind_t'($urandom_range(0, 6))));
                next_table_at = random_rows + RowsPerTable;
            end
            else if ($urandom_range(0, 19) == 0)
                drain_rows();

            height = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            case ($urandom_range(0, 19))
                0:       width = 0;
                1:       width = 63;
                2, 3:    width = MaxWidth;
                4:       width = 1;
                default: width = $urandom_range(1, MaxWidth);
            endcase
            mixed_width  = ($urandom_range(0, 7) == 0);
            mixed_border = ($urandom_range(0, 7) == 0);
            border       = $urandom_range(0, 1);
            for (int r = 0; r < height; r++)
            begin
                pix = rand_pixels();
                case ($urandom_range(0, 9))
                    0: pix = '0;
                    1: pix = '1;
                    default: ;
                endcase
                send_row(pix,
                         mixed_width ? WidthBits'($urandom_range(0, 63)) : WidthBits'(width),
                         mixed_border ? 1'($urandom_range(0, 1)) : border,
                         r == height - 1);
                random_rows++;
            end
        end

        // wait for the last rows, then let any stray rows show up
        drain_rows();
        repeat (SettleCycles) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_binary_neighbourhood_lut_filter_top: PASS");
        else
            $display("tb_binary_neighbourhood_lut_filter_top: FAIL");
        $finish;
    end

endmodule
